### rtl/smalu_pkg.sv
package smalu_pkg;

    localparam int WORD_W   = 32;
    localparam int ACTION_W = 3;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SUB  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_MUL  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DIV  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_MOD  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_DIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                latch;
        logic                rd_issue;
        logic                exec;
        logic                div_start;
        logic                div_capture;
        logic                commit;
        logic                set_status;
        logic [STATUS_W-1:0] status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_push;
        logic is_op;
        logic is_div;
        logic full;
        logic short_stack;
        logic div_zero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/smalu_req_if.sv
interface smalu_req_if;
    import smalu_pkg::*;

    logic                       valid;
    logic                       ready;
    logic        [ACTION_W-1:0] action;
    logic signed [WORD_W-1:0]   push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink (input valid, input action, input push_value, output ready);
endinterface

### rtl/smalu_rsp_if.sv
interface smalu_rsp_if;
    import smalu_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [WORD_W-1:0]   top_value;
    logic        [COUNT_W-1:0]  stack_count;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, output top_value, output stack_count, output status,
                    input ready);
    modport sink (input valid, input top_value, input stack_count, input status,
                  output ready);
endinterface

### rtl/smalu_ram.sv
module smalu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/smalu_div.sv
module smalu_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [smalu_pkg::WORD_W-1:0]  dividend,
    input  logic [smalu_pkg::WORD_W-1:0]  divisor,
    input  logic                          want_rem,
    output logic                          done,
    output logic [smalu_pkg::WORD_W-1:0]  result
);
    import smalu_pkg::*;

    localparam int STEP_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic              a_neg_reg;
    logic              b_neg_reg;
    logic              want_rem_reg;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;

    assign mag_a  = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b  = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
    assign rem_sh = {rem_reg, quo_reg[WORD_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= '0;
            quo_reg      <= mag_a;
            dvs_reg      <= mag_b;
            a_neg_reg    <= dividend[WORD_W-1];
            b_neg_reg    <= divisor[WORD_W-1];
            want_rem_reg <= want_rem;
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[WORD_W] ? rem_sh[WORD_W-1:0] : diff[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], ~diff[WORD_W]};
        end
    end

    always_comb
    begin
        if (want_rem_reg)
        begin
            result = a_neg_reg ? (~rem_reg + 1'b1) : rem_reg;
        end
        else
        begin
            result = (a_neg_reg != b_neg_reg) ? (~quo_reg + 1'b1) : quo_reg;
        end
    end

    assign done = done_reg;
endmodule

### rtl/smalu_dp.sv
module smalu_dp #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  smalu_pkg::ctrl_cmd_t            cmd,
    output smalu_pkg::dp_stat_t             stat,
    input  logic [smalu_pkg::ACTION_W-1:0]  action,
    input  logic [smalu_pkg::WORD_W-1:0]    push_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [smalu_pkg::WORD_W-1:0]    top_value,
    output logic [smalu_pkg::COUNT_W-1:0]   stack_count,
    output logic [smalu_pkg::STATUS_W-1:0]  status
);
    import smalu_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [ACTION_W-1:0] action_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [WORD_W-1:0]   res_reg;
    logic [WORD_W-1:0]   top_reg;
    logic [CW-1:0]       count_reg;
    logic                out_valid_reg;
    logic [WORD_W-1:0]   out_top_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [CW-1:0]       count_next;
    logic [WORD_W-1:0]   top_next;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [CW-1:0]       second_idx;
    logic [WORD_W-1:0]   second;
    logic [WORD_W-1:0]   div_result;
    logic                div_done;
    logic                ok;

    assign second_idx = count_reg - CW'(2);
    assign ok         = (status_reg == ST_OK);

    smalu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (second_idx[AW-1:0]),
        .rdata (second)
    );

    smalu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (second),
        .divisor  (top_reg),
        .want_rem (action_reg == ACT_MOD),
        .done     (div_done),
        .result   (div_result)
    );

    always_comb
    begin
        stat.is_push     = (action_reg == ACT_PUSH);
        stat.is_op       = (action_reg inside {[ACT_ADD:ACT_MOD]});
        stat.is_div      = (action_reg == ACT_DIV) || (action_reg == ACT_MOD);
        stat.full        = (count_reg >= CW'(STACK_DEPTH));
        stat.short_stack = (count_reg < CW'(2));
        stat.div_zero    = (top_reg == '0);
        stat.div_done    = div_done;
        stat.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[AW-1:0];
        ram_wdata  = value_reg;
        if (cmd.commit && ok)
        begin
            if (stat.is_push)
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CW'(1);
                top_next   = value_reg;
            end
            else if (stat.is_op)
            begin
                ram_we     = 1'b1;
                ram_waddr  = second_idx[AW-1:0];
                ram_wdata  = res_reg;
                count_next = count_reg - CW'(1);
                top_next   = res_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= action;
            value_reg  <= push_value;
            status_reg <= ST_OK;
        end
        else if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end

        if (cmd.exec)
        begin
            case (action_reg)
                ACT_ADD: res_reg <= second + top_reg;
                ACT_SUB: res_reg <= second - top_reg;
                ACT_MUL: res_reg <= second * top_reg;
                default: res_reg <= '0;
            endcase
        end
        else if (cmd.div_capture)
        begin
            res_reg <= div_result;
        end

        top_reg <= top_next;

        if (cmd.commit)
        begin
            out_top_reg    <= (count_next == '0) ? '0 : top_next;
            out_count_reg  <= COUNT_W'(count_next);
            out_status_reg <= status_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_value   = out_top_reg;
    assign stack_count = out_count_reg;
    assign status      = out_status_reg;
endmodule

### rtl/smalu_ctrl.sv
module smalu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  smalu_pkg::dp_stat_t  stat,
    output smalu_pkg::ctrl_cmd_t cmd
);
    import smalu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                if (stat.is_push)
                begin
                    if (stat.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FULL;
                    end
                end
                else if (stat.is_op)
                begin
                    if (stat.short_stack)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_SHORT;
                    end
                    else
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                if (stat.is_div)
                begin
                    if (stat.div_zero)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_DIVZERO;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

### rtl/stack_machine_alu.sv
// Stack of signed 32-bit words with add, sub, mul, div and mod.
// req carries one transaction per item: action (push, add, sub, mul, div,
// mod; other codes do nothing) and push_value. rsp returns exactly one
// transaction per item: top of stack after the item (0 when empty), entry
// count, and status (ok, stack too short, division by zero, stack full).
// Errors leave the stack untouched.
// Items are taken one at a time: the next req transaction is accepted
// once the current item completes. add, sub, mul, div and mod also read
// the second entry; div and mod then run 32 radix-2 divider steps.
// The result appears on rsp in the cycle after the item completes.
// Reset empties the stack and clears rsp.valid; no clearing pass is run.
// When rsp stalls, the block still accepts the next item and works on it,
// then holds at its final step until the pending result is taken.
module stack_machine_alu #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    smalu_req_if.sink          req,
    smalu_rsp_if.source        rsp
);
    import smalu_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    smalu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    smalu_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (req.action),
        .push_value  (req.push_value),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .top_value   (rsp.top_value),
        .stack_count (rsp.stack_count),
        .status      (rsp.status)
    );
endmodule
